>>> rtl/weighted_5x5_image_blur_top_defines.svh
// Assertion macros used by the blur top level.
`ifndef WEIGHTED_5X5_IMAGE_BLUR_TOP_DEFINES_SVH
`define WEIGHTED_5X5_IMAGE_BLUR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define GB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blur assertion failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define GB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blur assertion failed");

`endif

>>> rtl/gblur_pkg.sv
// Shared types, constants and helpers of the 5x5 weighted blur.
`default_nettype none
package gblur_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 5;
    localparam int WIN           = 5;
    localparam int LINES         = 4;
    localparam int CH_W          = 8;
    localparam int NUM_CH        = 3;
    localparam int PIX_W         = CH_W * NUM_CH;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int HGT_W         = ROW_W + 1;
    localparam int DIM_W         = 14;

    // config register map
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_DATA_W    = 13;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;

    // weighted sum and divide by 51: q = (sum * 20561) >> 20, exact for sum < 2^14
    localparam int SUM_W         = 14;
    localparam int DIV_MULT      = 20561;
    localparam int DIV_MULT_W    = 15;
    localparam int DIV_SHIFT     = 20;
    localparam int PROD_W        = SUM_W + DIV_MULT_W;

    // output queue
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);
    localparam int PEND_W        = 3;

    // blur mask, row 0 is the oldest line, column 4 the newest pixel
    localparam logic [3:0] BLUR_MASK [WIN][WIN] = '{
        '{4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1},
        '{4'd1, 4'd4, 4'd8, 4'd4, 4'd2},
        '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1},
        '{4'd1, 4'd1, 4'd2, 4'd1, 4'd1}
    };

    // one window column: rows oldest (0) to newest (4)
    typedef struct packed {
        logic                       vld;
        logic                       emit;
        logic                       fend;
        logic [WIN-1:0][PIX_W-1:0]  pix;
    } t_col;

    // filtered word headed for the output queue
    typedef struct packed {
        logic               vld;
        logic               fend;
        logic [PIX_W-1:0]   pix;
    } t_res;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < DIM_W'(MIN_DIM)) begin
            res = DIM_W'(MIN_DIM);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/gblur_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/gblur_lbuf.sv
// Position counters and line store with read-modify-write and bypass.
`default_nettype none
module gblur_lbuf #(
    parameter int MAX_WIDTH = gblur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_acc,
    input  wire logic [gblur_pkg::PIX_W-1:0]      i_pix,
    input  wire logic                             i_sof,
    input  wire logic [$clog2(MAX_WIDTH):0]       i_w,
    input  wire logic [gblur_pkg::HGT_W-1:0]      i_h,
    output gblur_pkg::t_col                       o_col
);
    import gblur_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int LW = LINES * PIX_W;

    typedef logic [LINES-1:0][PIX_W-1:0] t_lword;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [WW-1:0]    c_inc;
    logic [HGT_W-1:0] r_inc;
    logic             cur_emit, cur_fend;

    logic             r_s1_vld;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_c;
    logic [1:0]       r_s1_slot;
    logic             r_s1_emit, r_s1_fend;

    logic             r_byp_hit;
    t_lword           r_byp_word;
    logic [LW-1:0]    ram_rdata;
    t_lword           rd_word, n_wword;

    // position of the word being accepted, next position
    always_comb begin
        cur_c = i_sof ? '0 : r_col;
        cur_r = i_sof ? '0 : r_row;
        c_inc = {1'b0, cur_c} + WW'(1);
        r_inc = {1'b0, cur_r} + HGT_W'(1);
        n_col = r_col;
        n_row = r_row;
        if (i_acc) begin
            if (c_inc >= i_w) begin
                n_col = '0;
                n_row = (r_inc >= i_h) ? '0 : cur_r + ROW_W'(1);
            end else begin
                n_col = c_inc[CW-1:0];
                n_row = cur_r;
            end
        end
        cur_emit = (cur_r >= ROW_W'(WIN - 1)) && (cur_c >= CW'(WIN - 1));
        cur_fend = ({1'b0, cur_r} == i_h - HGT_W'(1)) &&
                   ({1'b0, cur_c} == i_w - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_s1_vld  <= i_acc;
            // same column written back while it is read: take the new word
            r_byp_hit <= i_acc && r_s1_vld && (cur_c == r_s1_c);
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_pix  <= i_pix;
            r_s1_c    <= cur_c;
            r_s1_slot <= cur_r[1:0];
            r_s1_emit <= cur_emit;
            r_s1_fend <= cur_fend;
        end
        r_byp_word <= n_wword;
    end

    // one RAM word holds the same column of all four stored lines
    gblur_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_c),
        .i_wdata (n_wword),
        .i_re    (i_acc),
        .i_raddr (cur_c),
        .o_rdata (ram_rdata)
    );

    // merge: the current line replaces the oldest one in its slot
    always_comb begin
        rd_word = r_byp_hit ? r_byp_word : t_lword'(ram_rdata);
        n_wword = rd_word;
        n_wword[r_s1_slot] = r_s1_pix;
        o_col.vld  = r_s1_vld;
        o_col.emit = r_s1_emit;
        o_col.fend = r_s1_fend;
        for (int i = 0; i < LINES; i++) begin
            o_col.pix[i] = rd_word[2'(r_s1_slot + 2'(i))];
        end
        o_col.pix[WIN-1] = r_s1_pix;
    end
endmodule
`default_nettype wire

>>> rtl/gblur_filt.sv
// 5x5 window and the weighted sum / divide-by-51 pipeline.
`default_nettype none
module gblur_filt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gblur_pkg::t_col              i_col,
    output gblur_pkg::t_res                   o_res,
    output logic [gblur_pkg::PEND_W-1:0]      o_pend
);
    import gblur_pkg::*;

    logic [PIX_W-1:0]  r_win [WIN][WIN];
    logic              r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld;
    logic              r_p2_fend, r_p3_fend, r_p4_fend, r_p5_fend;
    logic [SUM_W-1:0]  r_rsum [NUM_CH][WIN];
    logic [SUM_W-1:0]  n_rsum [NUM_CH][WIN];
    logic [SUM_W-1:0]  r_tot  [NUM_CH];
    logic [SUM_W-1:0]  n_tot  [NUM_CH];
    logic [PROD_W-1:0] r_prod [NUM_CH];

    // valid flags of emitting words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_p5_vld <= 1'b0;
        end else begin
            r_p2_vld <= i_col.vld && i_col.emit;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_p5_vld <= r_p4_vld;
        end
    end

    // window shifts left on every word, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (i_col.vld) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][WIN-1] <= i_col.pix[i];
            end
        end
    end

    // weighted row sums per channel
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            for (int i = 0; i < WIN; i++) begin
                n_rsum[c][i] = '0;
                for (int j = 0; j < WIN; j++) begin
                    n_rsum[c][i] = n_rsum[c][i] + SUM_W'(BLUR_MASK[i][j]) *
                                   SUM_W'(r_win[i][j][c*CH_W +: CH_W]);
                end
            end
        end
    end

    // add the five rows
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_tot[c] = '0;
            for (int i = 0; i < WIN; i++) begin
                n_tot[c] = n_tot[c] + r_rsum[c][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_fend <= i_col.fend;
        r_p3_fend <= r_p2_fend;
        r_p4_fend <= r_p3_fend;
        r_p5_fend <= r_p4_fend;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int i = 0; i < WIN; i++) begin
                r_rsum[c][i] <= n_rsum[c][i];
            end
            r_tot[c]  <= n_tot[c];
            // reciprocal multiply for the divide by 51
            r_prod[c] <= PROD_W'(r_tot[c]) * PROD_W'(DIV_MULT);
        end
    end

    always_comb begin
        o_res.vld  = r_p5_vld;
        o_res.fend = r_p5_fend;
        for (int c = 0; c < NUM_CH; c++) begin
            o_res.pix[c*CH_W +: CH_W] = r_prod[c][DIV_SHIFT +: CH_W];
        end
        o_pend = PEND_W'(r_p2_vld) + PEND_W'(r_p3_vld) +
                 PEND_W'(r_p4_vld) + PEND_W'(r_p5_vld);
    end
endmodule
`default_nettype wire

>>> rtl/gblur_ofifo.sv
// Small output queue that decouples the filter pipeline from the sink.
`default_nettype none
module gblur_ofifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    output logic                            o_rvalid,
    input  wire logic                       i_rready,
    output logic      [WIDTH-1:0]           o_rdata,
    output logic      [$clog2(DEPTH+1)-1:0] o_cnt
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_q [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [NW-1:0]    r_cnt;
    logic             pop;

    assign pop = (r_cnt != '0) && i_rready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= AW'((32'(r_wp) + 1) % DEPTH);
            end
            if (pop) begin
                r_rp <= AW'((32'(r_rp) + 1) % DEPTH);
            end
            r_cnt <= r_cnt + NW'(i_wr) - NW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_wdata;
        end
    end

    assign o_rvalid = (r_cnt != '0);
    assign o_rdata  = r_q[r_rp];
    assign o_cnt    = r_cnt;
endmodule
`default_nettype wire

>>> rtl/weighted_5x5_image_blur_top.sv
// Top level of the streaming 5x5 weighted RGB blur.
`default_nettype none
`include "weighted_5x5_image_blur_top_defines.svh"
// Takes one RGB pixel per clock in raster order (tuser marks the first
// pixel of a frame) and returns one blurred pixel per interior position,
// the window centre two lines and two columns behind the input; the
// two-pixel border is not emitted, and tlast marks the last interior
// pixel of the frame. Sustained rate is one pixel per clock: the line
// store is a single RAM whose word holds one column of all four stored
// lines, read on accept and written back next cycle, with a bypass for
// back-to-back hits on the same column. Words pass the line-store
// stage and the window, row-sum, total and product registers into an
// 8-word output queue that absorbs sink stalls; the input stalls only
// when the queue plus words in flight would fill it. The line store
// has no clearing pass; width and height must be written only while
// the block is idle, and are clamped to 5..MAX_WIDTH and 5..4096.
module weighted_5x5_image_blur_top #(
    parameter int MAX_WIDTH = gblur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [gblur_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel in
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                              s_axis_tuser,  // frame_start
    // pixel out
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [23:0]                       m_axis_tdata,  // red_out, green_out, blue_out
    output logic                                   m_axis_tlast   // frame_end
);
    import gblur_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH) + 1;

    logic [WW-1:0]      r_w;
    logic [HGT_W-1:0]   r_h;
    logic               acc;
    t_col               col;
    t_res               res;
    logic [PEND_W-1:0]  pend;
    logic [FIFO_CW-1:0] fifo_cnt;
    logic [FIFO_CW:0]   used;

    // config registers hold clamped dimensions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(clamp_dim(DIM_W'(RST_WIDTH), DIM_W'(MAX_WIDTH)));
            r_h <= HGT_W'(clamp_dim(DIM_W'(RST_HEIGHT), DIM_W'(MAX_HEIGHT)));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH: begin
                    r_w <= WW'(clamp_dim(DIM_W'(i_cfg_data[CFG_W_BITS-1:0]),
                                         DIM_W'(MAX_WIDTH)));
                end
                CFG_IDX_HEIGHT: begin
                    r_h <= HGT_W'(clamp_dim(DIM_W'(i_cfg_data[CFG_H_BITS-1:0]),
                                            DIM_W'(MAX_HEIGHT)));
                end
                default: begin
                end
            endcase
        end
    end

    // accept while the queue has room for every word in flight
    assign used          = (FIFO_CW+1)'(fifo_cnt) + (FIFO_CW+1)'(col.vld && col.emit) +
                           (FIFO_CW+1)'(pend);
    assign s_axis_tready = i_rst_n && (used < (FIFO_CW+1)'(FIFO_DEPTH));
    assign acc           = s_axis_tvalid && s_axis_tready;

    gblur_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_pix   (s_axis_tdata),
        .i_sof   (s_axis_tuser),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_col   (col)
    );

    gblur_filt u_filt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (col),
        .o_res   (res),
        .o_pend  (pend)
    );

    gblur_ofifo #(
        .WIDTH (PIX_W + 1),
        .DEPTH (FIFO_DEPTH)
    ) u_ofifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (res.vld),
        .i_wdata  ({res.fend, res.pix}),
        .o_rvalid (m_axis_tvalid),
        .i_rready (m_axis_tready),
        .o_rdata  ({m_axis_tlast, m_axis_tdata}),
        .o_cnt    (fifo_cnt)
    );

    // queue never overflows
    `GB_ASSERT_IMPL(a_fifo_room, res.vld, fifo_cnt < FIFO_CW'(FIFO_DEPTH))
    // every accepted word reaches the line-store merge stage next cycle
    `GB_ASSERT_NEXT(a_acc_to_s1, s_axis_tvalid && s_axis_tready, col.vld)
    // the last interior pixel is always an emitted one
    `GB_ASSERT_IMPL(a_fend_emit, col.vld && col.fend, col.emit)
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench of the streaming 5x5 weighted RGB blur.
module testbench;
    import gblur_pkg::*;

    localparam int MASK_SUM     = 51;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int BLUR_WEIGHTS [5][5] = '{
        '{1, 1, 2, 1, 1},
        '{1, 2, 4, 2, 1},
        '{1, 4, 8, 4, 2},
        '{1, 2, 4, 2, 1},
        '{1, 1, 2, 1, 1}
    };
    // idle mix per random phase: none, sender only, receiver only, both
    localparam int SEND_IDLE  [4] = '{0, 86, 0, 26};
    localparam int RECV_STALL [4] = '{0, 0, 86, 26};

    typedef struct packed {
        logic       hold;   // sender waits for all results before this word
        logic       start;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic       fend;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_blur_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;  // red_in, green_in, blue_in
    logic                  s_axis_tuser = 1'b0; // frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;        // red_out, green_out, blue_out
    logic                  m_axis_tlast;        // frame_end

    weighted_5x5_image_blur_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stimulus and expectations
    t_pixel     pixel_queue[$];
    t_blur_word blur_expected[$];
    t_pixel     in_flight;
    int         items_pending = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    // Predictor state: registers, line store, window, raster position
    logic [10:0] width_reg = 11'(RST_WIDTH);
    logic [12:0] height_reg = 13'(RST_HEIGHT);
    logic [23:0] line_mem [4][MAX_WIDTH_DEF] = '{default: '0};
    logic [23:0] win [5][5] = '{default: '0};
    int          col_pos = 0;
    int          row_pos = 0;

    function automatic int bounded_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the raster position by one pixel and queue the filtered word it yields
    task automatic predict_blur(input t_pixel px);
        int w, h, r, c;
        int sum_r, sum_g, sum_b;
        logic [23:0] word;
        t_blur_word res;
        w = bounded_dim(width_reg, MAX_WIDTH_DEF);
        h = bounded_dim(height_reg, MAX_HEIGHT);
        word = {px.blue, px.green, px.red};
        if (px.start) begin
            col_pos = 0;
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        if (c >= MAX_WIDTH_DEF) c = MAX_WIDTH_DEF - 1;
        // shift left, new column from the four stored lines plus the new pixel
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                win[i][j] = win[i][j + 1];
        for (int i = 0; i < 4; i++)
            win[i][4] = line_mem[(r + i) % 4][c];
        win[4][4] = word;
        line_mem[r % 4][c] = word;
        if (r >= 4 && c >= 4) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 5; j++) begin
                    sum_r += BLUR_WEIGHTS[i][j] * win[i][j][7:0];
                    sum_g += BLUR_WEIGHTS[i][j] * win[i][j][15:8];
                    sum_b += BLUR_WEIGHTS[i][j] * win[i][j][23:16];
                end
            end
            res.red   = 8'(sum_r / MASK_SUM);
            res.green = 8'(sum_g / MASK_SUM);
            res.blue  = 8'(sum_b / MASK_SUM);
            res.fend  = (r == h - 1) && (c == w - 1);
            blur_expected.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver: predict on accept, then load the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_blur(in_flight);
                items_pending--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(pixel_queue[0].hold && blur_expected.size() != 0)) begin
                    in_flight = pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {in_flight.blue, in_flight.green, in_flight.red};
                    s_axis_tuser  <= in_flight.start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_blur_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (blur_expected.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    want = blur_expected.pop_front();
                    check_field("red", want.red, m_axis_tdata[7:0]);
                    check_field("green", want.green, m_axis_tdata[15:8]);
                    check_field("blue", want.blue, m_axis_tdata[23:16]);
                    check_field("frame_end", {7'd0, want.fend}, {7'd0, m_axis_tlast});
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_pixel(input t_pixel px);
        pixel_queue.push_back(px);
        items_pending++;
    endtask

    // Channel values lean toward the extremes now and then
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue a run of random pixels; restart_pct sprinkles stray frame starts
    task automatic push_run(input int count, input bit start_first, input int hold_at,
                            input int restart_pct);
        t_pixel px;
        for (int k = 0; k < count; k++) begin
            px.red   = pick_channel();
            px.green = pick_channel();
            px.blue  = pick_channel();
            px.start = (k == 0) ? start_first : ($urandom_range(0, 99) < restart_pct);
            px.hold  = (k == hold_at);
            queue_pixel(px);
        end
    endtask

    // Block is idle: all words sent, all results in, pipeline flushed
    task automatic wait_idle();
        while (items_pending != 0 || blur_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_IDX_WIDTH) width_reg = data[10:0];
        else height_reg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sequence
    initial begin
        int phase, kind, w, h, w2, n, random_count;
        logic [CFG_DATA_W-1:0] width_val, height_val;
        t_pixel px;
        random_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: minimum frame via clamped registers, channel extremes
        write_reg(CFG_IDX_WIDTH, 13'd2);
        write_reg(CFG_IDX_HEIGHT, 13'd0);
        for (int k = 0; k < 25; k++) begin
            px.red   = 8'hFF;
            px.green = 8'h00;
            px.blue  = k[0] ? 8'hFF : 8'h00;
            px.start = (k == 0);
            px.hold  = 1'b0;
            queue_pixel(px);
        end
        wait_idle();

        // Tallest frame (height clamped to the top), first lines only
        write_reg(CFG_IDX_WIDTH, 13'd0);
        write_reg(CFG_IDX_HEIGHT, 13'h1FFF);
        push_run(50, 1'b1, -1, 0);
        wait_idle();

        // Widest line (width clamped to the top), start of the first line only
        write_reg(CFG_IDX_WIDTH, 13'd2047);
        write_reg(CFG_IDX_HEIGHT, 13'd5);
        push_run(60, 1'b1, -1, 0);
        wait_idle();

        // Small full frame, sender pauses mid-frame until every result is in
        write_reg(CFG_IDX_WIDTH, 13'd8);
        write_reg(CFG_IDX_HEIGHT, 13'd6);
        push_run(48, 1'b1, 40, 0);
        wait_idle();

        // Random runs over small frames, idle mix stepping through the phases
        while (random_count < RANDOM_ITEMS) begin
            phase = random_count * 4 / RANDOM_ITEMS;
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            wait_idle();
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 7))
                0:       width_val = 13'($urandom_range(0, 4));
                1:       width_val = 13'h1800 | 13'($urandom_range(5, 12));
                default: width_val = 13'($urandom_range(5, 12));
            endcase
            if (kind == 8) width_val = 13'($urandom_range(7, 12));
            if ($urandom_range(0, 7) == 0) height_val = 13'($urandom_range(0, 4));
            else height_val = 13'($urandom_range(5, 8));
            write_reg(CFG_IDX_WIDTH, width_val);
            write_reg(CFG_IDX_HEIGHT, height_val);
            w = bounded_dim(width_val[10:0], MAX_WIDTH_DEF);
            h = bounded_dim(height_val, MAX_HEIGHT);
            case (kind)
                // partial frame, then width lowered mid-frame and the stream goes on
                8: begin
                    n = w * $urandom_range(4, h - 1) + $urandom_range(0, w - 1);
                    push_run(n, 1'b1, -1, 0);
                    wait_idle();
                    w2 = $urandom_range(5, w - 1);
                    write_reg(CFG_IDX_WIDTH, 13'(w2));
                    write_reg(CFG_IDX_HEIGHT, 13'($urandom_range(5, 8)));
                    push_run(w2 * 3, 1'b0, -1, 0);
                    n += w2 * 3;
                end
                // heavy restart noise
                9: begin
                    n = $urandom_range(10, 40);
                    push_run(n, 1'b1, -1, 30);
                end
                // broken frame with stray restarts, then a clean frame
                6, 7: begin
                    n = $urandom_range(1, w * h);
                    push_run(n, 1'b1, -1, 15);
                    push_run(w * h, 1'b1, -1, 0);
                    n += w * h;
                end
                // one or two clean frames, the second wrapping without a start
                default: begin
                    n = w * h * $urandom_range(1, 2);
                    push_run(n, 1'b1, ($urandom_range(0, 1) == 0) ?
                             $urandom_range(1, n - 1) : -1, 0);
                end
            endcase
            random_count += n;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> weighted_5x5_image_blur_top.f
+incdir+rtl
rtl/gblur_pkg.sv
rtl/gblur_ram.sv
rtl/gblur_lbuf.sv
rtl/gblur_filt.sv
rtl/gblur_ofifo.sv
rtl/weighted_5x5_image_blur_top.sv
verif/testbench.sv
